[design/fdpa_pkg.sv]
// Package for the float32 dual-path adder: field constants and a 25-bit
// leading-zero count. No dependencies.
package fdpa_pkg;

   localparam logic [23:0] HIDDEN_BIT = 24'h800000;
   localparam int unsigned NEAR_W = 25;

   // Leading zeros of a 25-bit value; 25 when zero.
   function automatic logic [4:0] lzc25(input logic [24:0] v);
      logic [4:0] c;
      logic       found;
      c = 5'd25;
      found = 1'b0;
      for (int i = 24; i >= 0; i--) begin
         if (!found && v[i]) begin
            c = 5'(24 - i);
            found = 1'b1;
         end
      end
      return c;
   endfunction

endpackage

[design/float32_dual_path_adder_unit.sv]
// Float32 dual-path truncating adder, top level with input and result
// registers. Depends on fdpa_pkg and fdpa_core.
//
// Usage:
//   req_ channel carries {operand_b, operand_a} in req_tdata.
//   rsp_ channel carries sum_word in rsp_tdata.
//   An accepted transfer reaches rsp_ through two register stages in
//   order: input register, then result register.
//   Throughput: one item per cycle; both stages advance whenever the
//   result register is empty or being emptied.
//   A stalled receiver holds the result register; the input stage keeps
//   accepting until both stages are full, then req_tready drops.
//   Reset clears both valid flags; no item is in flight afterwards.
//   The adder itself is one pass of combinational logic between the
//   two registers; nothing is kept from one item to the next.
module float32_dual_path_adder_unit
   import fdpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] sum_word
);

   logic        in_vld_ff, in_vld_in, out_vld_ff, out_vld_in;
   logic [63:0] in_data_ff;
   logic [31:0] out_data_ff, sum;
   logic        out_adv, in_adv;

   fdpa_core u_core (
      .operand_a (in_data_ff[31:0]),
      .operand_b (in_data_ff[63:32]),
      .sum_word  (sum)
   );

   // stage advance control
   assign out_adv    = !out_vld_ff || rsp_tready;
   assign in_adv     = !in_vld_ff || out_adv;
   assign req_tready = in_adv;
   assign in_vld_in  = in_adv ? req_tvalid : in_vld_ff;
   assign out_vld_in = out_adv ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_adv) in_data_ff <= req_tdata;
      if (out_adv) out_data_ff <= sum;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[design/fdpa_core.sv]
// Combinational sum of two single-precision words, truncated.
// Depends on fdpa_pkg.
module fdpa_core
   import fdpa_pkg::*;
(
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic [31:0] sum_word
);

   logic        sa, sb, sgn, sub;
   logic [7:0]  ea, eb, diff, big_e, ex;
   logic [22:0] fa, fb, big_f, hi_f, lo_f;
   logic [23:0] small_src, small_al, far_sub;
   logic [24:0] lo_sh, near_d, near_sh, far_add;
   logic [4:0]  cnt;

   always_comb begin
      sa = operand_a[31];
      sb = operand_b[31];
      ea = operand_a[30:23];
      eb = operand_b[30:23];
      fa = operand_a[22:0];
      fb = operand_b[22:0];
      sub = sa ^ sb;

      // alignment of the smaller-exponent operand
      if (ea > eb) begin
         diff = ea - eb; big_e = ea; big_f = fa; small_src = HIDDEN_BIT | {1'b0, fb};
      end else begin
         diff = eb - ea; big_e = eb; big_f = fb; small_src = HIDDEN_BIT | {1'b0, fa};
      end
      small_al = (diff < 8'd24) ? (small_src >> diff) : 24'd0;

      // sign from larger magnitude, ties to operand_b
      if (operand_a[30:0] > operand_b[30:0]) begin
         sgn = sa; hi_f = fa; lo_f = fb;
      end else begin
         sgn = sb; hi_f = fb; lo_f = fa;
      end

      // near path
      if (ea[0] == eb[0]) lo_sh = {1'b1, lo_f, 1'b0};
      else                lo_sh = {2'b01, lo_f};
      near_d  = {1'b1, hi_f, 1'b0} - lo_sh;
      cnt     = lzc25(near_d);
      near_sh = near_d << cnt;
      if (cnt == 5'd25 || {3'd0, cnt} > big_e) ex = 8'd0;
      else ex = big_e - {3'd0, cnt};

      // far path
      far_add = {1'b0, HIDDEN_BIT | {1'b0, big_f}} + {1'b0, small_al};
      far_sub = (HIDDEN_BIT | {1'b0, big_f}) - small_al;

      if (ea == 8'd0 || eb == 8'd0)
         sum_word = {sgn, big_e, big_f};
      else if (sub && diff[7:1] == 7'd0)
         sum_word = {sgn, ex, near_sh[23:1]};
      else if (!sub) begin
         if (!far_add[24]) sum_word = {sgn, big_e, far_add[22:0]};
         else sum_word = {sgn, big_e + 8'd1, far_add[23:1]};
      end else begin
         if (far_sub[23]) sum_word = {sgn, big_e, far_sub[22:0]};
         else sum_word = {sgn, big_e - 8'd1, far_sub[21:0], 1'b0};
      end
   end

endmodule

[design/fdpa_checker.sv]
// Port-level checks for the float32 dual-path adder, bound to the top.
// Depends on float32_dual_path_adder_unit ports only.
module fdpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an idle output stage never blocks input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // a transfer with a free path shows up after the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing");

   // nothing appears right out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind float32_dual_path_adder_unit fdpa_checker u_fdpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/tb_top.sv]
// Testbench for float32_dual_path_adder_unit: random and directed operand pairs,
// sums predicted in-bench and checked in order. Depends on the RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] operand_a, [63:32] operand_b
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] sum_word

   logic [63:0] operand_queue[$];
   logic [31:0] sum_queue[$];
   int          fail_count = 0;
   bit          stim_done = 1'b0;
   bit          sender_pause = 1'b0;
   bit          req_accepted = 1'b0;
   int          hold_off = 0;
   int          send_gap = 0;
   int          recv_gap = 0;

   float32_dual_path_adder_unit dut (.*);

   always #5 clock = ~clock;

   // Leading zeros of a 25-bit value, 25 when zero.
   function automatic int count_lead25(input logic [24:0] v);
      for (int i = 24; i >= 0; i--) if (v[i]) return 24 - i;
      return 25;
   endfunction

   // Truncating dual-path sum of two single-precision words.
   function automatic logic [31:0] trunc_sum(input logic [31:0] a, input logic [31:0] b);
      logic [7:0]  ea, eb, big_e, diff, ex;
      logic [22:0] fa, fb, big_f, hi_f, lo_f;
      logic [23:0] small_al, t24;
      logic [24:0] lo_sh, near_d, t25;
      logic        sgn;
      int          cnt;
      ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
      if (ea > eb) begin
         diff = ea - eb; big_e = ea; big_f = fa;
         small_al = (diff < 24) ? ({1'b1, fb} >> diff) : 24'd0;
      end else begin
         diff = eb - ea; big_e = eb; big_f = fb;
         small_al = (diff < 24) ? ({1'b1, fa} >> diff) : 24'd0;
      end
      if (a[30:0] > b[30:0]) begin
         sgn = a[31]; hi_f = fa; lo_f = fb;
      end else begin
         sgn = b[31]; hi_f = fb; lo_f = fa;
      end
      if (ea == 0 || eb == 0) return {sgn, big_e, big_f};
      if ((a[31] ^ b[31]) && diff <= 1) begin
         // near path: cancel, then normalize by leading-zero count
         lo_sh = (ea[0] == eb[0]) ? {1'b1, lo_f, 1'b0} : {2'b01, lo_f};
         near_d = {1'b1, hi_f, 1'b0} - lo_sh;
         cnt = count_lead25(near_d);
         ex = (cnt == 25 || cnt > big_e) ? 8'd0 : big_e - 8'(cnt);
         t25 = near_d << cnt;
         return {sgn, ex, t25[23:1]};
      end
      if (!(a[31] ^ b[31])) begin
         t25 = {2'b01, big_f} + {1'b0, small_al};
         if (!t25[24]) return {sgn, big_e, t25[22:0]};
         return {sgn, big_e + 8'd1, t25[23:1]};
      end
      t24 = {1'b1, big_f} - small_al;
      if (t24[23]) return {sgn, big_e, t24[22:0]};
      return {sgn, big_e - 8'd1, t24[21:0], 1'b0};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: sum_word got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: w[30:23] = 8'd0;
         1: w[30:23] = 8'hFF;
         2: w[30:23] = 8'($urandom_range(1, 3));
         default: ;
      endcase
      return w;
   endfunction

   // Input transfer seen at the last rising edge.
   always @(posedge clock) begin
      req_accepted <= req_tvalid && req_tready;
   end

   // Driver: offers queued pairs, changes inputs on the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_accepted) begin
            // hold current transfer
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!sender_pause && operand_queue.size() > 0) begin
            req_tdata <= operand_queue.pop_front();
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 3);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready pattern, with one long hold-off counted here.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
               recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 3);
         end
      end
   end

   // Monitor: predict on input transfer, check on result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sum_queue.push_back(trunc_sum(req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (sum_queue.size() == 0) report_mismatch("unexpected", rsp_tdata, 32'd0);
            else begin
               logic [31:0] want;
               want = sum_queue.pop_front();
               if (rsp_tdata !== want) report_mismatch("value", rsp_tdata, want);
            end
         end
      end
   end

   initial begin
      logic [31:0] dir_a[] = '{32'h3F800000, 32'h3F800000, 32'hBF800000, 32'h00000000,
                               32'h00400000, 32'h7F800000, 32'hFFFFFFFF, 32'h00800000,
                               32'h3F800001, 32'h3F800000, 32'h4B000000, 32'h7F7FFFFF,
                               32'h40000000, 32'h3F800000, 32'h80000000, 32'h01000000};
      logic [31:0] dir_b[] = '{32'h3F800000, 32'hBF800000, 32'h3F800000, 32'h00000000,
                               32'h00000000, 32'h7F800000, 32'h7FFFFFFF, 32'h80800001,
                               32'hBF800000, 32'hBFFFFFFF, 32'h3F800000, 32'h7F7FFFFF,
                               32'hBFFFFFFF, 32'h33000000, 32'h00000000, 32'h80FFFFFF};
      foreach (dir_a[i]) operand_queue.push_back({dir_b[i], dir_a[i]});
      for (int i = 0; i < 600; i++) begin
         logic [31:0] a, b;
         a = rand_word();
         b = rand_word();
         // bias toward near-path cancellation
         if ($urandom_range(0, 2) == 0) begin
            b[31] = ~a[31];
            b[30:23] = a[30:23] + 8'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) b[22:0] = a[22:0] ^ (23'd1 << $urandom_range(0, 22));
         end
         operand_queue.push_back({b, a});
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // long receiver stall while sender keeps offering
      @(negedge clock);
      hold_off = 200;
      wait (operand_queue.size() == 0);
      // sender pause until all results drained
      @(negedge clock);
      sender_pause = 1'b1;
      wait (sum_queue.size() == 0 && !req_tvalid);
      for (int i = 0; i < 600; i++) operand_queue.push_back({rand_word(), rand_word()});
      @(negedge clock);
      sender_pause = 1'b0;
      wait (operand_queue.size() == 0 && !req_tvalid);
      wait (sum_queue.size() == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
